[rtl/tlspd_pkg.sv]
// ----------------------------------------------------------------------------
// tlspd_pkg
// Types and constants shared by the two-LED status pattern driver.
// ----------------------------------------------------------------------------
package tlspd_pkg;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_SET_SYS = 2'd1,
    MODE_SET_BUS = 2'd2,
    MODE_FRAME   = 2'd3
  } mode_e;

  localparam logic [2:0] SYS_OTA     = 3'd6;
  localparam logic [2:0] SYS_WIPING  = 3'd7;
  localparam logic [1:0] BUS_HEALTHY = 2'd1;
  localparam logic [1:0] BUS_GARBAGE = 2'd2;

  // register word index (paddr[2])
  localparam logic REG_BLIP_LEN = 1'b0;

  localparam int unsigned BLIP_W = 20;
  localparam logic [BLIP_W-1:0] BLIP_RESET = 20'd30000;

  // 50000 us per slot = 16 * 3125
  localparam int unsigned SLOT_SHIFT  = 4;
  localparam int unsigned SLOT_DIV    = 3125;
  localparam int unsigned CHUNK_W     = 10;
  localparam int unsigned CHUNKS      = 6;
  localparam int unsigned X_W         = CHUNK_W * CHUNKS;
  localparam int unsigned FOLD_W      = 31;
  localparam int unsigned REM_MAX_W   = 18;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP = 19'd343598;
  localparam int unsigned SLOT_W      = 6;

  typedef struct packed {
    logic [2:0] sys;
    logic [1:0] bus;
    logic       lit;
  } meta_t;

  localparam logic [7:0][63:0] STATUS_PAT = {
    64'h0000_00FF_FFFF_FFFF,  // wiping
    64'h0000_0033_3333_3333,  // ota
    64'h0000_0055_5555_5555,  // fatal
    64'h0000_00FF_FFFF_FFFE,  // nominal
    64'h0000_0000_0000_0001,  // connected
    64'h0000_0000_0000_001B,  // disconnected
    64'h0000_0033_3333_3333,  // ap
    64'h0000_00FF_FFFF_FFFF   // booting
  };

  localparam logic [63:0] PAT_OTA_BLUE = 64'h0000_00CC_CCCC_CCCC;
  localparam logic [63:0] PAT_GARBAGE  = 64'h0000_0018_C631_8C63;

endpackage

[rtl/tlspd_div_stage.sv]
// ----------------------------------------------------------------------------
// tlspd_div_stage
// Slot index from elapsed time in 16 us units, over four registered steps:
// fold the chunks modulo 3125 * SLOT_COUNT, reciprocal quotient, remainder,
// and slot = remainder / 3125.
// ----------------------------------------------------------------------------
module tlspd_div_stage #(
  parameter int unsigned SLOT_COUNT = 40
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [tlspd_pkg::X_W-1:0]    x_i,
  input  tlspd_pkg::meta_t             meta_i,
  output logic                         valid_o,
  output logic [tlspd_pkg::SLOT_W-1:0] slot_o,
  output tlspd_pkg::meta_t             meta_o
);
  import tlspd_pkg::*;

  localparam int unsigned MOD     = SLOT_DIV * SLOT_COUNT;
  localparam int unsigned MOD_W   = $clog2(MOD);
  localparam int unsigned Q_SHIFT = FOLD_W + MOD_W;
  localparam int unsigned Q_W     = FOLD_W + 1 - MOD_W;
  localparam int unsigned P_W     = CHUNK_W + REM_MAX_W;
  localparam int unsigned QP_W    = 2 * FOLD_W + 1;
  localparam int unsigned SP_W    = REM_MAX_W + RECIP_W;
  localparam logic [FOLD_W:0] RECIP_Q =
    (FOLD_W+1)'(((64'd1 << Q_SHIFT) + 64'(MOD) - 64'd1) / 64'(MOD));
  localparam logic [REM_MAX_W-1:0] MOD_V = REM_MAX_W'(MOD);

  typedef logic [CHUNKS-1:0][REM_MAX_W-1:0] weights_t;

  // weight of chunk i is 2^(CHUNK_W*i) modulo MOD
  function automatic weights_t fold_weights();
    weights_t w;
    for (int i = 0; i < CHUNKS; i++) begin
      w[i] = REM_MAX_W'((64'd1 << (CHUNK_W * i)) % 64'(MOD));
    end
    return w;
  endfunction

  localparam weights_t WEIGHT = fold_weights();

  logic [FOLD_W-1:0]    fold_d;
  logic [QP_W-1:0]      quot_prod;
  logic [Q_W-1:0]       quot_d;
  logic [FOLD_W-1:0]    back;
  logic [FOLD_W-1:0]    rem_full;
  logic [REM_MAX_W-1:0] rem_d;
  logic [SP_W-1:0]      slot_prod;
  logic [SLOT_W-1:0]    slot_d;

  logic                 a_v_q, b_v_q, c_v_q, d_v_q;
  logic [FOLD_W-1:0]    a_fold_q, b_fold_q;
  logic [Q_W-1:0]       b_quot_q;
  logic [REM_MAX_W-1:0] c_rem_q;
  logic [SLOT_W-1:0]    d_slot_q;
  meta_t                a_meta_q, b_meta_q, c_meta_q, d_meta_q;

  // sum stays below 2^30
  always_comb begin
    logic [P_W-1:0] part;
    fold_d = '0;
    for (int i = 0; i < CHUNKS; i++) begin
      part   = P_W'(x_i[i*CHUNK_W +: CHUNK_W]) * P_W'(WEIGHT[i]);
      fold_d = fold_d + FOLD_W'(part);
    end
  end

  assign quot_prod = QP_W'(a_fold_q) * QP_W'(RECIP_Q);
  assign quot_d    = quot_prod[Q_SHIFT +: Q_W];

  assign back     = FOLD_W'(b_quot_q) * FOLD_W'(MOD_V);
  assign rem_full = b_fold_q - back;
  assign rem_d    = rem_full[REM_MAX_W-1:0];

  assign slot_prod = SP_W'(c_rem_q) * SP_W'(RECIP);
  assign slot_d    = slot_prod[RECIP_SHIFT +: SLOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_fold_q <= fold_d;
      a_meta_q <= meta_i;
      b_fold_q <= a_fold_q;
      b_quot_q <= quot_d;
      b_meta_q <= a_meta_q;
      c_rem_q  <= rem_d;
      c_meta_q <= b_meta_q;
      d_slot_q <= slot_d;
      d_meta_q <= c_meta_q;
    end
  end

  assign valid_o = d_v_q;
  assign slot_o  = d_slot_q;
  assign meta_o  = d_meta_q;

endmodule

[rtl/two_led_status_pattern_driver.sv]
// ----------------------------------------------------------------------------
// two_led_status_pattern_driver
// Status and activity LED levels from 40-slot, 50 ms blink patterns.
//
//   channel | dir | signals                                   | moves
//   in      | in  | in_valid_i/in_ready_o, mode_i, now_us_i,  | one transaction
//           |     | system_state_i, bus_state_i               | per item
//   out     | out | out_valid_o/out_ready_i, status_led_o,    | one per tick
//           |     | activity_led_o                            |
//   cfg     | in  | psel/penable/pwrite/paddr/pwdata/prdata   | APB, pready = 1
//
// One item per cycle, but a tick in the input register waits while the output
// is stalled. A tick result passes the input register, state update, chunk
// fold, quotient, remainder, slot multiply and output register. Other items
// only update state and give no result. Reset clears all control state; no
// clearing pass. A stalled output freezes the pipeline; the input register
// still drains non-tick items.
// ----------------------------------------------------------------------------
module two_led_status_pattern_driver #(
  parameter int unsigned SLOT_COUNT = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [62:0] now_us_i,
  input  logic [2:0]  system_state_i,
  input  logic [1:0]  bus_state_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_led_o,
  output logic        activity_led_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tlspd_pkg::*;

  // configuration
  logic [BLIP_W-1:0] blip_len_q;
  logic              cfg_wr;

  // input register
  logic        in_v_q;
  mode_e       in_mode_q;
  logic [62:0] in_now_q;
  logic [2:0]  in_sys_q;
  logic [1:0]  in_bus_q;
  logic        in_adv;
  logic        consume;
  logic        en;

  // block state
  logic [2:0]  sys_q, sys_d;
  logic [1:0]  bus_q, bus_d;
  logic [62:0] start_q, start_d;
  logic [63:0] deadline_q, deadline_d;
  logic        armed_q, armed_d;

  logic [62:0] start_eff;
  logic [62:0] diff;
  logic        lit;

  // entry to the slot pipeline
  logic             e0_v_q;
  logic [X_W-1:0]   e0_x_q;
  meta_t            e0_meta_q;

  // slot stage and output
  logic                          sl_v;
  logic [SLOT_W-1:0]             sl_slot;
  meta_t                         sl_meta;
  logic                          out_v_q;
  logic                          status_q;
  logic                          activity_q;
  logic                          status_d;
  logic                          activity_d;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blip_len_q <= BLIP_RESET;
    end else if (cfg_wr && paddr[2] == REG_BLIP_LEN) begin
      blip_len_q <= pwdata[BLIP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BLIP_LEN) ? 32'(blip_len_q) : 32'd0;

  // ---------------- input register ----------------
  assign en         = ~out_v_q | out_ready_i;
  assign in_adv     = ~in_v_q | en | (in_mode_q != MODE_TICK);
  assign in_ready_o = in_adv;
  assign consume    = in_v_q & in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_adv) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      in_mode_q <= mode_e'(mode_i);
      in_now_q  <= now_us_i;
      in_sys_q  <= system_state_i;
      in_bus_q  <= bus_state_i;
    end
  end

  // ---------------- state update ----------------
  assign start_eff = (start_q == '0) ? in_now_q : start_q;
  assign diff      = (in_now_q >= start_eff) ? (in_now_q - start_eff) : '0;
  assign lit       = armed_q ? (blip_len_q != '0) : ({1'b0, in_now_q} < deadline_q);

  always_comb begin
    sys_d      = sys_q;
    bus_d      = bus_q;
    start_d    = start_q;
    deadline_d = deadline_q;
    armed_d    = armed_q;
    if (consume) begin
      case (in_mode_q)
        MODE_SET_SYS: begin
          if (in_sys_q != sys_q) begin
            sys_d   = in_sys_q;
            start_d = '0;
          end
        end
        MODE_SET_BUS: begin
          bus_d = in_bus_q;
        end
        MODE_FRAME: begin
          armed_d = 1'b1;
        end
        MODE_TICK: begin
          start_d = start_eff;
          if (armed_q) begin
            armed_d    = 1'b0;
            deadline_d = {1'b0, in_now_q} + 64'(blip_len_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_q      <= '0;
      bus_q      <= '0;
      start_q    <= '0;
      deadline_q <= '0;
      armed_q    <= 1'b0;
    end else begin
      sys_q      <= sys_d;
      bus_q      <= bus_d;
      start_q    <= start_d;
      deadline_q <= deadline_d;
      armed_q    <= armed_d;
    end
  end

  // ---------------- entry 0 ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_v_q <= 1'b0;
    end else if (en) begin
      e0_v_q <= in_v_q & (in_mode_q == MODE_TICK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_x_q    <= X_W'(diff >> SLOT_SHIFT);
      e0_meta_q <= '{sys: sys_q, bus: bus_q, lit: lit};
    end
  end

  // ---------------- slot from elapsed time ----------------
  tlspd_div_stage #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e0_v_q),
    .x_i     (e0_x_q),
    .meta_i  (e0_meta_q),
    .valid_o (sl_v),
    .slot_o  (sl_slot),
    .meta_o  (sl_meta)
  );

  // ---------------- pattern lookup ----------------
  always_comb begin
    status_d = STATUS_PAT[sl_meta.sys][sl_slot];
    if (sl_meta.sys == SYS_OTA) begin
      activity_d = PAT_OTA_BLUE[sl_slot];
    end else if (sl_meta.sys == SYS_WIPING) begin
      activity_d = 1'b1;
    end else if (sl_meta.bus == BUS_GARBAGE) begin
      activity_d = PAT_GARBAGE[sl_slot];
    end else if (sl_meta.bus == BUS_HEALTHY) begin
      activity_d = sl_meta.lit;
    end else begin
      activity_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= sl_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q   <= status_d;
      activity_q <= activity_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign status_led_o   = status_q;
  assign activity_led_o = activity_q;

`ifndef SYNTH
  a_sys_change_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_mode_q == MODE_SET_SYS && in_sys_q != sys_q) |=> (start_q == '0))
    else $error("cycle start not cleared on system change");

  a_start_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q != '0 && !(consume && in_mode_q == MODE_SET_SYS)) |=> $stable(start_q))
    else $error("cycle start moved without system change");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_v_q && out_v_q && !out_ready_i))
    else $error("input stalled while pipeline can move");

  a_tick_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_mode_q == MODE_TICK) |=> !armed_q)
    else $error("blip still armed after tick");
`endif

endmodule
